[rtl/spc_pkg.sv]
package spc_pkg;

  localparam int DefMaxKernel = 15;
  localparam int DefMaxLine = 1024;
  localparam int DefMaxUnits = 64;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits = 11;

  localparam logic [CfgIndexBits-1:0] REG_KERNEL_WIDTH = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_KERNEL_HEIGHT = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_UNITS_X = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_UNITS_Y = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_OVERLAP = 3'd4;
  localparam logic [CfgIndexBits-1:0] REG_IMAGE_WIDTH = 3'd5;
  localparam logic [CfgIndexBits-1:0] REG_IMAGE_HEIGHT = 3'd6;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic wr_weight;
    logic take_pixel;
    logic div_start;
    logic div_y;
    logic save_x;
    logic save_y;
    logic calc_index;
    logic mac_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic patch_hit;
    logic div_done;
    logic unit_ok;
    logic mac_last;
    logic pipe_empty;
    logic out_busy;
  } status_t;

endpackage

[rtl/strided_patch_convolution.sv]
// Strided single-kernel convolution over a raster stream of 8-bit pixels. An item with
// op low writes one Q1.15 weight, an item with op high delivers the next pixel; both are
// taken in the idle state, and the input stays ready unless the pixel completes a patch.
// Such a pixel holds the input while two bit-serial divisions place the patch in the unit
// grid; if it lands on a unit, one multiply-accumulate per cycle then reads the weight
// memory and the line store. The result sits in an output register, so the next item is
// taken while it waits.
module strided_patch_convolution #(
  parameter int MAX_KERNEL = spc_pkg::DefMaxKernel,
  parameter int MAX_LINE = spc_pkg::DefMaxLine,
  parameter int MAX_UNITS = spc_pkg::DefMaxUnits
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [7:0]                        weight_index,
  input  logic signed [15:0]                weight_value,
  input  logic [7:0]                        pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [11:0]                       unit_index,
  output logic signed [31:0]                activation,
  output logic                              last_unit,
  input  logic                              cfg_we,
  input  logic [spc_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [spc_pkg::CfgDataBits-1:0]   cfg_data
);

  import spc_pkg::*;

  cmd_t    cmd;
  status_t status;

  spc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .status(status),
    .cmd(cmd)
  );

  spc_dp #(
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_LINE(MAX_LINE),
    .MAX_UNITS(MAX_UNITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .weight_index(weight_index),
    .weight_value(weight_value),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .unit_index(unit_index),
    .activation(activation),
    .last_unit(last_unit)
  );

endmodule

[rtl/spc_ram.sv]
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/spc_div.sv]
module spc_div #(
  parameter int NUM_BITS = 10,
  parameter int DEN_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient,
  output logic [DEN_BITS-1:0] remainder
);

  localparam int CntBits = $clog2(NUM_BITS);

  logic [CntBits-1:0]  cnt;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS:0]   shifted;
  logic                ge;

  assign shifted = {remainder, quotient[NUM_BITS-1]};
  assign ge = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CntBits'(NUM_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      den <= divisor;
      quotient <= dividend;
      remainder <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      quotient <= {quotient[NUM_BITS-2:0], ge};
      remainder <= ge ? DEN_BITS'(shifted - {1'b0, den}) : shifted[DEN_BITS-1:0];
    end
  end

endmodule

[rtl/spc_dp.sv]
module spc_dp #(
  parameter int MAX_KERNEL = spc_pkg::DefMaxKernel,
  parameter int MAX_LINE = spc_pkg::DefMaxLine,
  parameter int MAX_UNITS = spc_pkg::DefMaxUnits
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spc_pkg::cmd_t                     cmd,
  output spc_pkg::status_t                  status,
  input  logic                              cfg_we,
  input  logic [spc_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [spc_pkg::CfgDataBits-1:0]   cfg_data,
  input  logic [7:0]                        weight_index,
  input  logic signed [15:0]                weight_value,
  input  logic [7:0]                        pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [11:0]                       unit_index,
  output logic signed [31:0]                activation,
  output logic                              last_unit
);

  import spc_pkg::*;

  localparam int LW = $clog2(MAX_LINE);
  localparam int IWB = $clog2(MAX_LINE + 1);
  localparam int KB = $clog2(MAX_KERNEL + 1);
  localparam int LNB = $clog2(MAX_KERNEL);
  localparam int UB = $clog2(MAX_UNITS + 1);
  localparam int IB = 2 * UB;
  localparam int WAB = $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int LSB = $clog2(MAX_KERNEL * MAX_LINE);

  function automatic logic [KB-1:0] eff_kernel(input logic [3:0] v);
    int t;
    t = int'(v);
    if (t < 3) t = 3;
    if (t % 2 == 0) t = t + 1;
    if (t > MAX_KERNEL) begin
      t = MAX_KERNEL;
      if (t % 2 == 0) t = t - 1;
    end
    return KB'(t);
  endfunction

  function automatic logic [KB-1:0] eff_stride(input logic [KB-1:0] k, input logic [3:0] ov);
    int o;
    o = int'(ov);
    if (o > int'(k) - 1) o = int'(k) - 1;
    return KB'(int'(k) - o);
  endfunction

  function automatic int clamp_range(input int v, input int hi);
    if (v < 1) return 1;
    return v > hi ? hi : v;
  endfunction

  logic [3:0]  reg_kw, reg_kh, reg_ov;
  logic [6:0]  reg_nx, reg_ny;
  logic [10:0] reg_iw, reg_ih;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_kw <= 4'd3;
      reg_kh <= 4'd3;
      reg_nx <= 7'd1;
      reg_ny <= 7'd1;
      reg_ov <= 4'd0;
      reg_iw <= 11'd64;
      reg_ih <= 11'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_WIDTH:  reg_kw <= cfg_data[3:0];
        REG_KERNEL_HEIGHT: reg_kh <= cfg_data[3:0];
        REG_UNITS_X:       reg_nx <= cfg_data[6:0];
        REG_UNITS_Y:       reg_ny <= cfg_data[6:0];
        REG_OVERLAP:       reg_ov <= cfg_data[3:0];
        REG_IMAGE_WIDTH:   reg_iw <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  reg_ih <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic [KB-1:0]  kw, kh, sx, sy;
  logic [UB-1:0]  nx, ny;
  logic [IWB-1:0] iw, ih;

  assign kw = eff_kernel(reg_kw);
  assign kh = eff_kernel(reg_kh);
  assign sx = eff_stride(kw, reg_ov);
  assign sy = eff_stride(kh, reg_ov);
  assign nx = UB'(clamp_range(int'(reg_nx), MAX_UNITS));
  assign ny = UB'(clamp_range(int'(reg_ny), MAX_UNITS));
  assign iw = IWB'(clamp_range(int'(reg_iw), MAX_LINE));
  assign ih = IWB'(clamp_range(int'(reg_ih), MAX_LINE));

  logic [LW-1:0]  col, row;
  logic [LNB-1:0] line_sel;
  logic [IWB-1:0] col_inc, row_inc;

  assign col_inc = IWB'(col) + 1'b1;
  assign row_inc = IWB'(row) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      line_sel <= '0;
    end else if (cmd.take_pixel) begin
      if (col_inc >= iw) begin
        col <= '0;
        if (row_inc >= ih) begin
          row <= '0;
          line_sel <= '0;
        end else begin
          row <= row_inc[LW-1:0];
          line_sel <= (line_sel == LNB'(MAX_KERNEL - 1)) ? '0 : line_sel + 1'b1;
        end
      end else begin
        col <= col_inc[LW-1:0];
      end
    end
  end

  assign status.patch_hit = (IWB'(col) < iw) && (IWB'(row) < ih)
      && (int'(col) >= int'(kw) - 1) && (int'(row) >= int'(kh) - 1);

  logic [LW-1:0]  dx, dy;
  logic [LNB-1:0] pline;

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      dx <= col - LW'(kw - 1'b1);
      dy <= row - LW'(kh - 1'b1);
      pline <= line_sel;
    end
  end

  logic          div_busy, div_done;
  logic [LW-1:0] div_q;
  logic [KB-1:0] div_r;

  spc_div #(
    .NUM_BITS(LW),
    .DEN_BITS(KB)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .dividend(cmd.div_y ? dy : dx),
    .divisor(cmd.div_y ? sy : sx),
    .busy(div_busy),
    .done(div_done),
    .quotient(div_q),
    .remainder(div_r)
  );

  assign status.div_done = div_done;

  logic [LW-1:0] qx, qy;
  logic          rx_zero, ry_zero;

  always_ff @(posedge clk) begin
    if (cmd.save_x) begin
      qx <= div_q;
      rx_zero <= (div_r == '0);
    end
    if (cmd.save_y) begin
      qy <= div_q;
      ry_zero <= (div_r == '0);
    end
  end

  assign status.unit_ok = rx_zero && ry_zero && (int'(qx) < int'(nx)) && (int'(qy) < int'(ny));

  logic [IB-1:0] idx, nxny;

  always_ff @(posedge clk) begin
    if (cmd.calc_index) begin
      idx <= IB'(UB'(qy)) * IB'(nx) + IB'(UB'(qx));
      nxny <= IB'(nx) * IB'(ny);
    end
  end

  logic [LNB-1:0] rl;
  logic [LW-1:0]  xc;
  logic [KB-1:0]  cc, rc;
  logic [WAB-1:0] wa;

  assign status.mac_last = (cc == kw - 1'b1) && (rc == kh - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.calc_index) begin
      rl <= (pline >= LNB'(kh - 1'b1)) ? pline - LNB'(kh - 1'b1)
          : LNB'(int'(pline) + MAX_KERNEL - int'(kh) + 1);
      xc <= dx;
      cc <= '0;
      rc <= '0;
      wa <= '0;
    end else if (cmd.mac_issue) begin
      wa <= wa + 1'b1;
      if (cc == kw - 1'b1) begin
        cc <= '0;
        rc <= rc + 1'b1;
        xc <= dx;
        rl <= (rl == LNB'(MAX_KERNEL - 1)) ? '0 : rl + 1'b1;
      end else begin
        cc <= cc + 1'b1;
        xc <= xc + 1'b1;
      end
    end
  end

  logic [15:0] w_rd;
  logic [7:0]  p_rd;

  spc_ram #(
    .WIDTH(16),
    .DEPTH(MAX_KERNEL * MAX_KERNEL)
  ) u_weights (
    .clk(clk),
    .we(cmd.wr_weight && (int'(weight_index) < MAX_KERNEL * MAX_KERNEL)),
    .waddr(WAB'(weight_index)),
    .wdata(weight_value),
    .raddr(wa),
    .rdata(w_rd)
  );

  spc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_KERNEL * MAX_LINE)
  ) u_lines (
    .clk(clk),
    .we(cmd.take_pixel),
    .waddr(LSB'(line_sel) * LSB'(MAX_LINE) + LSB'(col)),
    .wdata(pixel),
    .raddr(LSB'(rl) * LSB'(MAX_LINE) + LSB'(xc)),
    .rdata(p_rd)
  );

  logic               v1, v2;
  logic signed [24:0] prod;
  logic signed [31:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= $signed(w_rd) * $signed({1'b0, p_rd});
    end
    if (cmd.calc_index) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + 32'(prod);
    end
  end

  assign status.pipe_empty = !v1 && !v2;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unit_index <= 12'(idx);
      activation <= acc;
      last_unit <= (idx == nxny - 1'b1);
    end
  end

`ifndef ASSERT_OFF
  a_load_drained: assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |-> !v1 && !v2)
    else $error("result loaded before the accumulation drained");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |-> !out_valid || out_ready)
    else $error("result overwrote an item still waiting");
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
      cmd.div_start |=> div_busy)
    else $error("divider did not start");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
      cmd.calc_index |=> idx < nxny)
    else $error("unit index beyond the grid");
`endif

endmodule

[rtl/spc_ctrl.sv]
module spc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  spc_pkg::status_t  status,
  output spc_pkg::cmd_t     cmd
);

  import spc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_DIVX  = 8'b0000_0100,
    S_DIVY  = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_MAC   = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_WEIGHT) begin
            cmd.wr_weight = 1'b1;
          end else begin
            cmd.take_pixel = 1'b1;
            if (status.patch_hit) state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        if (status.div_done) begin
          cmd.save_x = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_y = 1'b1;
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_y = 1'b1;
        if (status.div_done) begin
          cmd.save_y = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.unit_ok) begin
          cmd.calc_index = 1'b1;
          state_next = S_MAC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.mac_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.pipe_empty) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[tb/tb.sv]
module tb;
  import spc_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = 300;
  localparam int RegWidth[7] = '{4, 4, 7, 7, 4, 11, 11};

  typedef struct {
    logic [11:0] unit_index;
    logic signed [31:0] activation;
    logic last_unit;
  } unit_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic op;
  logic [7:0] weight_index;
  logic signed [15:0] weight_value;
  logic [7:0] pixel;
  logic out_valid;
  logic out_ready;
  logic [11:0] unit_index;
  logic signed [31:0] activation;
  logic last_unit;
  logic cfg_we;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  strided_patch_convolution u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .weight_index(weight_index), .weight_value(weight_value), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit_index(unit_index), .activation(activation), .last_unit(last_unit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic signed [15:0] coef_mem [DefMaxKernel*DefMaxKernel];
  logic [7:0] line_mem [DefMaxKernel*DefMaxLine];
  int col_pos, row_pos, units_done;
  int cfg_reg [7];

  unit_result_t pending_units[$];
  int err_count;
  int units_seen;
  int pixels_sent;
  int cycle_count;
  int hold_cycles;
  int rx_stall;
  bit hold_req;
  bit offer_open;
  bit quiet;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int eff_kernel(int v);
    if (v < 3) v = 3;
    if ((v & 1) == 0) v++;
    if (v > DefMaxKernel) v = DefMaxKernel;
    return v;
  endfunction

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic convolve_pixel(input logic [7:0] px, output bit hit, output unit_result_t res);
    int kw, kh, nx, ny, iw, ih, sx, sy, dx, dy, ov, ux, uy, idx;
    longint acc;
    kw = eff_kernel(cfg_reg[REG_KERNEL_WIDTH]);
    kh = eff_kernel(cfg_reg[REG_KERNEL_HEIGHT]);
    nx = clamp_to(cfg_reg[REG_UNITS_X], DefMaxUnits);
    ny = clamp_to(cfg_reg[REG_UNITS_Y], DefMaxUnits);
    iw = clamp_to(cfg_reg[REG_IMAGE_WIDTH], DefMaxLine);
    ih = clamp_to(cfg_reg[REG_IMAGE_HEIGHT], DefMaxLine);
    hit = 1'b0;
    res = '{default: '0};
    if (col_pos < DefMaxLine) line_mem[(row_pos % DefMaxKernel) * DefMaxLine + col_pos] = px;
    if (col_pos < iw && row_pos < ih && col_pos >= kw - 1 && row_pos >= kh - 1) begin
      ov = cfg_reg[REG_OVERLAP];
      sx = kw - ((ov > kw - 1) ? kw - 1 : ov);
      sy = kh - ((ov > kh - 1) ? kh - 1 : ov);
      dx = col_pos - (kw - 1);
      dy = row_pos - (kh - 1);
      if (dx % sx == 0 && dy % sy == 0 && dx / sx < nx && dy / sy < ny) begin
        ux = dx / sx;
        uy = dy / sy;
        idx = uy * nx + ux;
        acc = 0;
        for (int r = 0; r < kh; r++) begin
          for (int c = 0; c < kw; c++) begin
            acc += longint'(coef_mem[r * kw + c]) *
                   longint'({1'b0, line_mem[((dy + r) % DefMaxKernel) * DefMaxLine + dx + c]});
          end
        end
        res.unit_index = idx[11:0];
        res.activation = acc[31:0];
        res.last_unit = (idx == nx * ny - 1);
        units_done = (units_done + 1) & 12'hFFF;
        hit = 1'b1;
      end
    end
    col_pos++;
    if (col_pos >= iw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ih) begin
        row_pos = 0;
        units_done = 0;
      end
    end
  endtask

  task automatic send_item(input logic o, input logic [7:0] wi, input logic [15:0] wv,
                           input logic [7:0] px);
    int gap;
    bit hit;
    unit_result_t res;
    in_valid <= 1'b1;
    op <= o;
    weight_index <= wi;
    weight_value <= wv;
    pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o == OP_WEIGHT) begin
      if (wi < DefMaxKernel * DefMaxKernel) coef_mem[wi] = wv;
    end else begin
      convolve_pixel(px, hit, res);
      if (hit) pending_units.push_back(res);
    end
    gap = gap_len();
    offer_open = (gap == 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (offer_open) begin
      in_valid <= 1'b0;
      offer_open = 1'b0;
    end
    while (pending_units.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_config(input int kw, input int kh, input int ux, input int uy,
                            input int ov, input int iw, input int ih);
    int vals [7];
    vals = '{kw, kh, ux, uy, ov, iw, ih};
    wait_idle();
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CfgIndexBits-1:0];
      cfg_data <= vals[i][CfgDataBits-1:0];
      @(posedge clk);
      cfg_reg[i] = vals[i] & ((1 << RegWidth[i]) - 1);
    end
    cfg_we <= 1'b0;
  endtask

  // Mode 1 loads the most negative weight everywhere, mode 2 the most positive.
  task automatic load_weights(input int mode);
    int n;
    logic [15:0] w;
    n = eff_kernel(cfg_reg[REG_KERNEL_WIDTH]) * eff_kernel(cfg_reg[REG_KERNEL_HEIGHT]);
    for (int i = 0; i < n; i++) begin
      if (mode == 1) w = 16'h8000;
      else if (mode == 2) w = 16'h7FFF;
      else if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      else w = 16'($urandom);
      send_item(OP_WEIGHT, i[7:0], w, 8'($urandom));
    end
    send_item(OP_WEIGHT, 8'($urandom_range(225, 255)), 16'($urandom), 8'($urandom));
  endtask

  // A negative fill gives random pixels; minus two gives a checkerboard of the extremes.
  task automatic send_frame(input int fill, input bit noisy);
    int iw, ih;
    logic [7:0] px;
    iw = clamp_to(cfg_reg[REG_IMAGE_WIDTH], DefMaxLine);
    ih = clamp_to(cfg_reg[REG_IMAGE_HEIGHT], DefMaxLine);
    for (int r = 0; r < ih; r++) begin
      for (int c = 0; c < iw; c++) begin
        if (fill == -2) px = ((r + c) & 1) ? 8'hFF : 8'h00;
        else if (fill < 0) px = 8'($urandom);
        else px = fill[7:0];
        if (noisy && $urandom_range(0, 29) == 0) begin
          send_item(OP_WEIGHT, 8'($urandom_range(0, 1) ? $urandom_range(225, 255) :
                    $urandom_range(0, eff_kernel(cfg_reg[REG_KERNEL_WIDTH]) *
                                      eff_kernel(cfg_reg[REG_KERNEL_HEIGHT]) - 1)),
                    16'($urandom), 8'($urandom));
        end
        send_item(OP_PIXEL, 8'($urandom), 16'($urandom), px);
      end
    end
  endtask

  task automatic test_extreme_weights();
    set_config(1, 2, 1, 1, 0, 3, 3);
    load_weights(1);
    send_frame(255, 1'b0);
    load_weights(2);
    send_frame(-2, 1'b0);
    send_frame(0, 1'b0);
  endtask

  task automatic test_large_kernel();
    set_config(15, 14, 127, 3, 14, 17, 16);
    load_weights(0);
    send_frame(-1, 1'b0);
  endtask

  task automatic test_overlap_clamp();
    set_config(5, 5, 4, 2, 15, 8, 6);
    load_weights(0);
    send_frame(-1, 1'b1);
  endtask

  task automatic test_line_extremes();
    set_config(3, 3, 127, 1, 0, 12, 5);
    load_weights(0);
    send_frame(-1, 1'b0);
    set_config(3, 3, 0, 0, 0, 0, 24);
    send_frame(-1, 1'b0);
  endtask

  task automatic test_backpressure();
    set_config(3, 3, 8, 4, 2, 10, 6);
    load_weights(0);
    hold_req = 1'b1;
    send_frame(-1, 1'b0);
  endtask

  task automatic test_random();
    int kw, kh, frames;
    frames = 0;
    while (pixels_sent < 500 || units_seen < 60) begin
      kw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 7);
      kh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 7);
      set_config(kw, kh,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6),
                 $urandom_range(0, 15),
                 eff_kernel(kw) + $urandom_range(0, 10),
                 eff_kernel(kh) + $urandom_range(0, 6));
      quiet = (frames % 3 == 2);
      load_weights(0);
      send_frame(-1, 1'b1);
      pixels_sent += clamp_to(cfg_reg[REG_IMAGE_WIDTH], DefMaxLine) *
                     clamp_to(cfg_reg[REG_IMAGE_HEIGHT], DefMaxLine);
      frames++;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    unit_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        units_seen++;
        if (pending_units.size() == 0) begin
          $error("unit_index: expected none, actual %0d", unit_index);
          err_count++;
        end else begin
          want = pending_units.pop_front();
          if (unit_index !== want.unit_index) begin
            $error("unit_index: expected %0d, actual %0d", want.unit_index, unit_index);
            err_count++;
          end
          if (activation !== want.activation) begin
            $error("activation: expected %0d, actual %0d", want.activation, activation);
            err_count++;
          end
          if (last_unit !== want.last_unit) begin
            $error("last_unit: expected %0d, actual %0d", want.last_unit, last_unit);
            err_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet) begin
          case ($urandom_range(0, 19))
            0, 1, 2: rx_stall = $urandom_range(1, 3);
            3: rx_stall = $urandom_range(15, 50);
            default: rx_stall = 0;
          endcase
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_PIXEL;
    weight_index = '0;
    weight_value = '0;
    pixel = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    units_seen = 0;
    pixels_sent = 0;
    hold_cycles = 0;
    rx_stall = 0;
    hold_req = 1'b0;
    offer_open = 1'b0;
    quiet = 1'b0;
    col_pos = 0;
    row_pos = 0;
    units_done = 0;
    cfg_reg = '{3, 3, 1, 1, 0, 64, 64};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_weights();
    test_large_kernel();
    test_overlap_clamp();
    test_line_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
